[rtl/cckb_pkg.sv]
// ----------------------------------------------------------------------------
// cckb_pkg: shared types and constants of the color keyed clipped blit
// Register map, configuration struct and the payload of each pipeline stage.
// ----------------------------------------------------------------------------
package cckb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 768;

  localparam int COORD_W  = 12;  // window pixel column/row
  localparam int LAYER_W  = 13;  // layer position, signed
  localparam int SCR_W    = 14;  // screen coordinate and rectangle edge, signed
  localparam int ROW_W    = 12;  // screen row bits once the pixel is on screen
  localparam int STRIDE_W = 13;
  localparam int PROD_W   = ROW_W + STRIDE_W;
  localparam int ADDR_W   = 26;
  localparam int COLOR_W  = 8;
  localparam int MODE_W   = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYER_X     = 3'd0,
    REG_LAYER_Y     = 3'd1,
    REG_AREA_LEFT   = 3'd2,
    REG_AREA_TOP    = 3'd3,
    REG_AREA_RIGHT  = 3'd4,
    REG_AREA_BOTTOM = 3'd5,
    REG_SCAN_STRIDE = 3'd6,
    REG_PIXEL_MODE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [LAYER_W-1:0]  layer_x;
    logic [LAYER_W-1:0]  layer_y;
    logic [SCR_W-1:0]    area_left;
    logic [SCR_W-1:0]    area_top;
    logic [SCR_W-1:0]    area_right;
    logic [SCR_W-1:0]    area_bottom;
    logic [STRIDE_W-1:0] scan_stride;
    logic [MODE_W-1:0]   pixel_mode;
  } cfg_t;

  // stage 1 result: placed pixel and key compare
  typedef struct packed {
    logic [SCR_W-1:0]   sx;
    logic [SCR_W-1:0]   sy;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               key_hit;
  } s1_t;

  // stage 2 result: visibility and row offset
  typedef struct packed {
    logic               vis;
    logic [PROD_W-1:0]  row_ofs;
    logic [ROW_W-1:0]   col;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } s2_t;

endpackage

[rtl/clipped_color_key_pixel_blit.sv]
// ----------------------------------------------------------------------------
// clipped_color_key_pixel_blit: color keyed, clipped pixel blit
// Places a window pixel on screen, clips it and forms its framebuffer write.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a pixel transfer happens at a clock edge with start high and busy
//   low. busy is high only while rst_n is low, so one pixel can be taken
//   every cycle.
//   Output: each pixel gives one result, shown for exactly one cycle with
//   out_strobe high. out_write_enable says whether the framebuffer is written;
//   when it is low, address and bytes read zero.
//   Throughput: one pixel per cycle, through the three register stages
//   (place and key compare, clip and row multiply, address and bytes).
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
//   write it only with no pixel in flight.
//   Reset: synchronous; empties the pipeline and loads the register reset
//   values (all zero, scan stride 1024). The receiver cannot stall, so
//   there is no backpressure.
// ----------------------------------------------------------------------------
module clipped_color_key_pixel_blit #(
  parameter int SCREEN_WIDTH  = cckb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cckb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [cckb_pkg::COORD_W-1:0]    in_win_x,
  input  logic [cckb_pkg::COORD_W-1:0]    in_win_y,
  input  logic [cckb_pkg::COLOR_W-1:0]    in_red,
  input  logic [cckb_pkg::COLOR_W-1:0]    in_green,
  input  logic [cckb_pkg::COLOR_W-1:0]    in_blue,
  output logic                            out_strobe,
  output logic                            out_write_enable,
  output logic [cckb_pkg::ADDR_W-1:0]     out_byte_address,
  output logic [cckb_pkg::COLOR_W-1:0]    out_byte0,
  output logic [cckb_pkg::COLOR_W-1:0]    out_byte1,
  output logic [cckb_pkg::COLOR_W-1:0]    out_byte2,
  input  logic                            cfg_we,
  input  logic [cckb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cckb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cckb_pkg::*;

  cfg_t cfg;
  logic in_xfer;
  logic s1_valid;
  s1_t  s1;
  logic s2_valid;
  s2_t  s2;

  assign busy    = !rst_n;
  assign in_xfer = start && !busy;

  cckb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  cckb_place u_place (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .in_win_x   (in_win_x),
    .in_win_y   (in_win_y),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .cfg        (cfg),
    .s1_valid_r (s1_valid),
    .s1_r       (s1)
  );

  cckb_clip #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .cfg        (cfg),
    .s2_valid_r (s2_valid),
    .s2_r       (s2)
  );

  cckb_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .s2_valid           (s2_valid),
    .s2                 (s2),
    .cfg                (cfg),
    .out_strobe_r       (out_strobe),
    .out_write_enable_r (out_write_enable),
    .out_byte_address_r (out_byte_address),
    .out_byte0_r        (out_byte0),
    .out_byte1_r        (out_byte1),
    .out_byte2_r        (out_byte2)
  );

  // every accepted pixel produces a result
  a_xfer_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> ##2 out_strobe)
    else $error("accepted pixel did not produce a result");

  // no result without an accepted pixel
  a_result_from_xfer : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_xfer, 3))
    else $error("result without an accepted pixel");

  a_we_needs_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_write_enable |-> out_strobe)
    else $error("write enable outside a result cycle");

  // a dropped pixel carries all-zero payload
  a_drop_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_write_enable) |->
      (out_byte_address == '0 && out_byte0 == '0 && out_byte1 == '0 && out_byte2 == '0))
    else $error("dropped pixel with nonzero payload");

endmodule

[rtl/cckb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cckb_cfg_regs: configuration register file
// Eight write-only registers, truncated to their widths on write.
// ----------------------------------------------------------------------------
module cckb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cckb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cckb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cckb_pkg::cfg_t                  cfg_r
);
  import cckb_pkg::*;

  cfg_t cfg_nxt;
  cfg_t cfg_rst;

  // reset values: all zero except the scan stride
  always_comb begin
    cfg_rst             = '0;
    cfg_rst.scan_stride = STRIDE_RESET;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_X:     cfg_nxt.layer_x     = cfg_wdata[LAYER_W-1:0];
        REG_LAYER_Y:     cfg_nxt.layer_y     = cfg_wdata[LAYER_W-1:0];
        REG_AREA_LEFT:   cfg_nxt.area_left   = cfg_wdata[SCR_W-1:0];
        REG_AREA_TOP:    cfg_nxt.area_top    = cfg_wdata[SCR_W-1:0];
        REG_AREA_RIGHT:  cfg_nxt.area_right  = cfg_wdata[SCR_W-1:0];
        REG_AREA_BOTTOM: cfg_nxt.area_bottom = cfg_wdata[SCR_W-1:0];
        REG_SCAN_STRIDE: cfg_nxt.scan_stride = cfg_wdata[STRIDE_W-1:0];
        REG_PIXEL_MODE:  cfg_nxt.pixel_mode  = cfg_wdata[MODE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_rst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/cckb_place.sv]
// ----------------------------------------------------------------------------
// cckb_place: pipeline stage 1
// Moves the window pixel to screen coordinates and compares it to the key.
// ----------------------------------------------------------------------------
module cckb_place (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [cckb_pkg::COORD_W-1:0] in_win_x,
  input  logic [cckb_pkg::COORD_W-1:0] in_win_y,
  input  logic [cckb_pkg::COLOR_W-1:0] in_red,
  input  logic [cckb_pkg::COLOR_W-1:0] in_green,
  input  logic [cckb_pkg::COLOR_W-1:0] in_blue,
  input  cckb_pkg::cfg_t               cfg,
  output logic                         s1_valid_r,
  output cckb_pkg::s1_t                s1_r
);
  import cckb_pkg::*;

  s1_t  s1_nxt;
  logic key_en;

  assign key_en = cfg.pixel_mode[1];

  always_comb begin
    // sign-extended layer plus zero-extended window coordinate, no wrap in 14 bits
    s1_nxt.sx = {cfg.layer_x[LAYER_W-1], cfg.layer_x} + {2'b00, in_win_x};
    s1_nxt.sy = {cfg.layer_y[LAYER_W-1], cfg.layer_y} + {2'b00, in_win_y};
    s1_nxt.red     = in_red;
    s1_nxt.green   = in_green;
    s1_nxt.blue    = in_blue;
    s1_nxt.key_hit = key_en
                     && (in_red   == cfg.pixel_mode[9:2])
                     && (in_green == cfg.pixel_mode[17:10])
                     && (in_blue  == cfg.pixel_mode[25:18]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

[rtl/cckb_clip.sv]
// ----------------------------------------------------------------------------
// cckb_clip: pipeline stage 2
// Clips against the redraw rectangle and the screen, forms row times stride.
// ----------------------------------------------------------------------------
module cckb_clip #(
  parameter int SCREEN_WIDTH  = cckb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cckb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  input  cckb_pkg::s1_t  s1,
  input  cckb_pkg::cfg_t cfg,
  output logic           s2_valid_r,
  output cckb_pkg::s2_t  s2_r
);
  import cckb_pkg::*;

  localparam logic signed [SCR_W-1:0] SCR_RIGHT  = SCR_W'(SCREEN_WIDTH);
  localparam logic signed [SCR_W-1:0] SCR_BOTTOM = SCR_W'(SCREEN_HEIGHT);

  logic signed [SCR_W-1:0] sx;
  logic signed [SCR_W-1:0] sy;
  logic                    in_area;
  logic                    on_screen;
  s2_t                     s2_nxt;

  assign sx = $signed(s1.sx);
  assign sy = $signed(s1.sy);

  assign in_area = (sx >= $signed(cfg.area_left)) && (sx < $signed(cfg.area_right))
                && (sy >= $signed(cfg.area_top))  && (sy < $signed(cfg.area_bottom));
  assign on_screen = (sx >= $signed(SCR_W'(0))) && (sx < SCR_RIGHT)
                  && (sy >= $signed(SCR_W'(0))) && (sy < SCR_BOTTOM);

  always_comb begin
    s2_nxt.vis     = in_area && on_screen && !s1.key_hit;
    // once on screen the row fits in ROW_W bits; off-screen products are dropped
    s2_nxt.row_ofs = {{STRIDE_W{1'b0}}, s1.sy[ROW_W-1:0]}
                   * {{ROW_W{1'b0}}, cfg.scan_stride};
    s2_nxt.col     = s1.sx[ROW_W-1:0];
    s2_nxt.red     = s1.red;
    s2_nxt.green   = s1.green;
    s2_nxt.blue    = s1.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

endmodule

[rtl/cckb_emit.sv]
// ----------------------------------------------------------------------------
// cckb_emit: pipeline stage 3
// Adds the column, scales to bytes and orders the color bytes.
// ----------------------------------------------------------------------------
module cckb_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s2_valid,
  input  cckb_pkg::s2_t                s2,
  input  cckb_pkg::cfg_t               cfg,
  output logic                         out_strobe_r,
  output logic                         out_write_enable_r,
  output logic [cckb_pkg::ADDR_W-1:0]  out_byte_address_r,
  output logic [cckb_pkg::COLOR_W-1:0] out_byte0_r,
  output logic [cckb_pkg::COLOR_W-1:0] out_byte1_r,
  output logic [cckb_pkg::COLOR_W-1:0] out_byte2_r
);
  import cckb_pkg::*;

  logic [PROD_W-1:0]  pix_idx;
  logic               we_nxt;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [COLOR_W-1:0] byte0_nxt;
  logic [COLOR_W-1:0] byte1_nxt;
  logic [COLOR_W-1:0] byte2_nxt;

  assign pix_idx = s2.row_ofs + {{STRIDE_W{1'b0}}, s2.col};
  assign we_nxt  = s2_valid && s2.vis;

  always_comb begin
    addr_nxt  = '0;
    byte0_nxt = '0;
    byte1_nxt = '0;
    byte2_nxt = '0;
    if (we_nxt) begin
      // four bytes per pixel, address wraps at 26 bits
      addr_nxt  = {pix_idx[ADDR_W-3:0], 2'b00};
      byte0_nxt = cfg.pixel_mode[0] ? s2.red  : s2.blue;
      byte1_nxt = s2.green;
      byte2_nxt = cfg.pixel_mode[0] ? s2.blue : s2.red;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r       <= 1'b0;
      out_write_enable_r <= 1'b0;
    end else begin
      out_strobe_r       <= s2_valid;
      out_write_enable_r <= we_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_address_r <= addr_nxt;
    out_byte0_r        <= byte0_nxt;
    out_byte1_r        <= byte1_nxt;
    out_byte2_r        <= byte2_nxt;
  end

endmodule

[verif/tb_clipped_color_key_pixel_blit.sv]
// ----------------------------------------------------------------------------
// tb_clipped_color_key_pixel_blit: self-checking bench for the clipped blit
// Streams window pixels through the blit under a series of layer, rectangle,
// stride and key settings. Each taken pixel is predicted from a shadow copy
// of the registers. Every result strobe is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_clipped_color_key_pixel_blit;
  timeunit 1ns;
  timeprecision 1ps;

  import cckb_pkg::*;

  localparam int SCREEN_W = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H = SCREEN_HEIGHT_DEF;
  localparam int MAX_SHOWN = 100;

  typedef struct packed {
    logic [COORD_W-1:0] win_x;
    logic [COORD_W-1:0] win_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] b0;
    logic [COLOR_W-1:0] b1;
    logic [COLOR_W-1:0] b2;
  } fb_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_W-1:0]    in_win_x = '0;
  logic [COORD_W-1:0]    in_win_y = '0;
  logic [COLOR_W-1:0]    in_red = '0;
  logic [COLOR_W-1:0]    in_green = '0;
  logic [COLOR_W-1:0]    in_blue = '0;
  logic                  out_strobe;
  logic                  out_write_enable;
  logic [ADDR_W-1:0]     out_byte_address;
  logic [COLOR_W-1:0]    out_byte0;
  logic [COLOR_W-1:0]    out_byte1;
  logic [COLOR_W-1:0]    out_byte2;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cfg_t      shadow_cfg;
  pixel_t    pixel_backlog[$];
  fb_write_t expected_writes[$];
  int        pixels_queued = 0;
  int        pixels_taken = 0;
  int        mismatch_count = 0;
  int        gap_rate = 0;
  int        gap_left = 0;
  logic      pixel_taken = 1'b0;

  clipped_color_key_pixel_blit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_win_x         (in_win_x),
    .in_win_y         (in_win_y),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_strobe       (out_strobe),
    .out_write_enable (out_write_enable),
    .out_byte_address (out_byte_address),
    .out_byte0        (out_byte0),
    .out_byte1        (out_byte1),
    .out_byte2        (out_byte2),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // framebuffer write that one window pixel should produce
  function automatic fb_write_t place_pixel(pixel_t p);
    fb_write_t w;
    int        sx;
    int        sy;
    int        al;
    int        at;
    int        ar;
    int        ab;
    longint    addr;
    bit        shown;
    w  = '0;
    sx = int'($signed(shadow_cfg.layer_x)) + int'(p.win_x);
    sy = int'($signed(shadow_cfg.layer_y)) + int'(p.win_y);
    al = int'($signed(shadow_cfg.area_left));
    at = int'($signed(shadow_cfg.area_top));
    ar = int'($signed(shadow_cfg.area_right));
    ab = int'($signed(shadow_cfg.area_bottom));
    shown = sx >= al && sx < ar && sy >= at && sy < ab &&
            sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
    if (shown && shadow_cfg.pixel_mode[1] &&
        {p.blue, p.green, p.red} == shadow_cfg.pixel_mode[25:2])
      shown = 1'b0;
    if (shown) begin
      addr   = (longint'(sy) * longint'(shadow_cfg.scan_stride) + longint'(sx)) * 4;
      w.we   = 1'b1;
      w.addr = addr[ADDR_W-1:0];
      w.b1   = p.green;
      if (shadow_cfg.pixel_mode[0]) begin
        w.b0 = p.red;
        w.b2 = p.blue;
      end else begin
        w.b0 = p.blue;
        w.b2 = p.red;
      end
    end
    return w;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    if (mismatch_count < MAX_SHOWN)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // driver: one pixel per transfer, with random idle bursts
  always @(negedge clk) begin
    pixel_t px;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || pixel_taken) begin
      if (gap_left == 0 && gap_rate != 0 && pixel_backlog.size() != 0 &&
          $urandom_range(1, gap_rate) == 1)
        gap_left = int'($urandom_range(1, 18));
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        px = pixel_backlog.pop_front();
        start    <= 1'b1;
        in_win_x <= px.win_x;
        in_win_y <= px.win_y;
        in_red   <= px.red;
        in_green <= px.green;
        in_blue  <= px.blue;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each taken pixel, check each result strobe
  always @(posedge clk) begin
    fb_write_t want;
    pixel_taken <= start && !busy;
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_writes.size() == 0) begin
        flag_mismatch("unexpected result", longint'(out_write_enable), 0);
      end else begin
        want = expected_writes.pop_front();
        if (out_write_enable !== want.we)
          flag_mismatch("write_enable", longint'(out_write_enable), longint'(want.we));
        if (out_byte_address !== want.addr)
          flag_mismatch("byte_address", longint'(out_byte_address), longint'(want.addr));
        if (out_byte0 !== want.b0)
          flag_mismatch("byte0", longint'(out_byte0), longint'(want.b0));
        if (out_byte1 !== want.b1)
          flag_mismatch("byte1", longint'(out_byte1), longint'(want.b1));
        if (out_byte2 !== want.b2)
          flag_mismatch("byte2", longint'(out_byte2), longint'(want.b2));
      end
    end
    if (start && !busy) begin
      expected_writes.push_back(place_pixel({in_win_x, in_win_y, in_red, in_green, in_blue}));
      pixels_taken++;
    end
  end

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LAYER_X:     shadow_cfg.layer_x     = val[LAYER_W-1:0];
      REG_LAYER_Y:     shadow_cfg.layer_y     = val[LAYER_W-1:0];
      REG_AREA_LEFT:   shadow_cfg.area_left   = val[SCR_W-1:0];
      REG_AREA_TOP:    shadow_cfg.area_top    = val[SCR_W-1:0];
      REG_AREA_RIGHT:  shadow_cfg.area_right  = val[SCR_W-1:0];
      REG_AREA_BOTTOM: shadow_cfg.area_bottom = val[SCR_W-1:0];
      REG_SCAN_STRIDE: shadow_cfg.scan_stride = val[STRIDE_W-1:0];
      REG_PIXEL_MODE:  shadow_cfg.pixel_mode  = val[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(int lx, int ly, int al, int at, int ar, int ab, int stride,
                            logic [CFG_DATA_W-1:0] mode);
    set_reg(REG_LAYER_X, CFG_DATA_W'(lx));
    set_reg(REG_LAYER_Y, CFG_DATA_W'(ly));
    set_reg(REG_AREA_LEFT, CFG_DATA_W'(al));
    set_reg(REG_AREA_TOP, CFG_DATA_W'(at));
    set_reg(REG_AREA_RIGHT, CFG_DATA_W'(ar));
    set_reg(REG_AREA_BOTTOM, CFG_DATA_W'(ab));
    set_reg(REG_SCAN_STRIDE, CFG_DATA_W'(stride));
    set_reg(REG_PIXEL_MODE, mode);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(int x, int y, int r, int g, int b);
    pixel_t p;
    p.win_x = COORD_W'(x);
    p.win_y = COORD_W'(y);
    p.red   = COLOR_W'(r);
    p.green = COLOR_W'(g);
    p.blue  = COLOR_W'(b);
    pixel_backlog.push_back(p);
    pixels_queued++;
  endtask

  // every pixel has been taken and every result has come back
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || expected_writes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     tx;
    int     ty;
    p.win_x = COORD_W'($urandom_range(0, 4095));
    p.win_y = COORD_W'($urandom_range(0, 4095));
    p.red   = COLOR_W'($urandom_range(0, 255));
    p.green = COLOR_W'($urandom_range(0, 255));
    p.blue  = COLOR_W'($urandom_range(0, 255));
    // mostly aim at the screen, around its borders too
    if ($urandom_range(0, 4) != 0) begin
      tx = int'($urandom_range(0, SCREEN_W + 7)) - 4 - int'($signed(shadow_cfg.layer_x));
      ty = int'($urandom_range(0, SCREEN_H + 7)) - 4 - int'($signed(shadow_cfg.layer_y));
      if (tx >= 0 && tx < 4096)
        p.win_x = COORD_W'(tx);
      if (ty >= 0 && ty < 4096)
        p.win_y = COORD_W'(ty);
    end
    if (shadow_cfg.pixel_mode[1] && $urandom_range(0, 3) == 0) begin
      {p.blue, p.green, p.red} = shadow_cfg.pixel_mode[25:2];
      // near miss of the key color
      if ($urandom_range(0, 2) == 0)
        p.green = p.green ^ (8'd1 << $urandom_range(0, 7));
    end
    return p;
  endfunction

  task automatic run_random_phase(int count);
    int lx;
    int ly;
    int al;
    int at;
    int ar;
    int ab;
    int stride;
    lx = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                     : int'($urandom_range(0, 600)) - 300;
    ly = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                     : int'($urandom_range(0, 600)) - 300;
    case ($urandom_range(0, 4))
      0: begin
        al = 0;
        at = 0;
        ar = SCREEN_W;
        ab = SCREEN_H;
      end
      1: begin
        al = int'($urandom_range(0, 16383)) - 8192;
        at = int'($urandom_range(0, 16383)) - 8192;
        ar = int'($urandom_range(0, 16383)) - 8192;
        ab = int'($urandom_range(0, 16383)) - 8192;
      end
      2: begin
        // empty or inverted rectangle
        al = int'($urandom_range(0, 1100)) - 60;
        at = int'($urandom_range(0, 800)) - 60;
        ar = al - int'($urandom_range(0, 40));
        ab = ($urandom_range(0, 1) == 0) ? at - int'($urandom_range(0, 40))
                                         : at + int'($urandom_range(1, 400));
      end
      default: begin
        al = int'($urandom_range(0, 1100)) - 60;
        at = int'($urandom_range(0, 800)) - 60;
        ar = al + int'($urandom_range(1, 700));
        ab = at + int'($urandom_range(1, 500));
      end
    endcase
    case ($urandom_range(0, 9))
      0:       stride = 0;
      1:       stride = 8191;
      2:       stride = int'($urandom_range(0, 8191));
      default: stride = int'($urandom_range(1, 4096));
    endcase
    load_setup(lx, ly, al, at, ar, ab, stride,
               CFG_DATA_W'($urandom_range(0, 26'h3FFFFFF)));
    repeat (count) begin
      pixel_backlog.push_back(random_pixel());
      pixels_queued++;
    end
    wait_idle();
  endtask

  initial begin
    shadow_cfg = '0;
    shadow_cfg.scan_stride = STRIDE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset setting: the rectangle is empty, nothing is written
    queue_pixel(0, 0, 0, 0, 0);
    queue_pixel(4095, 4095, 255, 255, 255);
    wait_idle();

    // full screen, rgb order, key off: corners and just past the edges
    load_setup(0, 0, 0, 0, SCREEN_W, SCREEN_H, 1024, 26'h1);
    queue_pixel(0, 0, 0, 0, 0);
    queue_pixel(SCREEN_W - 1, SCREEN_H - 1, 255, 255, 255);
    queue_pixel(SCREEN_W, 0, 1, 2, 3);
    queue_pixel(0, SCREEN_H, 1, 2, 3);
    queue_pixel(4095, 4095, 255, 255, 255);
    queue_pixel(5, 3, 8'h12, 8'h34, 8'h56);
    wait_idle();

    // widest rectangle, stride 0, bgr order with the key on
    load_setup(-3, 2, -8192, -8192, 8191, 8191, 0,
               (26'h56 << 18) | (26'h34 << 10) | (26'h12 << 2) | 26'h2);
    queue_pixel(3, 0, 8'h12, 8'h34, 8'h56);
    queue_pixel(3, 0, 8'h12, 8'h34, 8'h57);
    queue_pixel(2, 0, 8'h12, 8'h34, 8'h57);
    queue_pixel(SCREEN_W + 2, SCREEN_H - 3, 8'haa, 8'h55, 8'h0f);
    queue_pixel(0, 4095, 8'h01, 8'h02, 8'h03);
    wait_idle();

    // layer at its extremes puts everything off screen
    load_setup(-4096, 4095, 0, 0, SCREEN_W, SCREEN_H, 8191, 26'h3FFFFFF);
    queue_pixel(4095, 0, 8'h10, 8'h20, 8'h30);
    queue_pixel(0, 0, 8'h10, 8'h20, 8'h30);
    wait_idle();

    // inverted rectangle
    load_setup(0, 0, 100, 100, 50, 50, 8191, 26'h1);
    queue_pixel(75, 75, 8'h10, 8'h20, 8'h30);
    wait_idle();

    // largest stride, key of all ones
    load_setup(1, 1, 0, 0, SCREEN_W, SCREEN_H, 8191, 26'h3FFFFFF);
    queue_pixel(SCREEN_W - 2, SCREEN_H - 2, 255, 255, 255);
    queue_pixel(SCREEN_W - 2, SCREEN_H - 2, 255, 255, 254);
    queue_pixel(0, 0, 0, 0, 0);
    wait_idle();

    for (int i = 0; i < 13; i++) begin
      if (i >= 11 || $urandom_range(0, 3) == 0)
        gap_rate = 0;
      else
        gap_rate = int'($urandom_range(3, 12));
      run_random_phase(145);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[clipped_color_key_pixel_blit.f]
rtl/cckb_pkg.sv
rtl/cckb_cfg_regs.sv
rtl/cckb_place.sv
rtl/cckb_clip.sv
rtl/cckb_emit.sv
rtl/clipped_color_key_pixel_blit.sv
verif/tb_clipped_color_key_pixel_blit.sv
